// File: rtl/core/cer_pkg.sv
package cer_pkg;

  localparam int MAX_DEPTH_DEF = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int QUEUED_W   = 5;
  localparam int DROP_W     = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_COAL_EN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTION     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OVF_TYPE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE_STD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OWNER_DEV  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH      = 3'd5;

  localparam logic [4:0] DEPTH_RESET = 5'd16;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_COALESCED = 3'd1,
    ST_DROPPED   = 3'd2,
    ST_POPPED    = 3'd3,
    ST_POP_OVF   = 3'd4,
    ST_EMPTY     = 3'd5
  } status_e;

  // Event fields, first field in the highest bits.
  typedef struct packed {
    logic        [31:0] event_time;
    logic        [31:0] event_sequence;
    logic signed [31:0] event_value;
    logic        [15:0] event_flags;
    logic        [15:0] std_code;
    logic        [15:0] event_code;
    logic        [15:0] event_device;
    logic        [4:0]  event_type;
  } entry_t;

  localparam int ENTRY_W  = $bits(entry_t);
  localparam int S_DATA_W = ((ENTRY_W + 7) / 8) * 8;

  typedef struct packed {
    logic        [QUEUED_W-1:0] queued;
    logic        [31:0]         ev_time;
    logic        [31:0]         ev_sequence;
    logic signed [31:0]         ev_value;
    logic        [15:0]         ev_flags;
    logic        [15:0]         ev_std;
    logic        [15:0]         ev_code;
    logic        [15:0]         ev_device;
    logic        [4:0]          ev_type;
    status_e                    status;
  } result_t;

  localparam int RESULT_W = $bits(result_t);
  localparam int M_DATA_W = ((RESULT_W + 7) / 8) * 8;

  typedef struct packed {
    logic rd_en;
    logic wr_all;
    logic wr_upd;
  } mem_ctl_t;

endpackage

// File: rtl/core/cer_mem.sv
module cer_mem #(
  parameter int DEPTH = cer_pkg::MAX_DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic               clk_i,
  input  cer_pkg::mem_ctl_t  ctl_i,
  input  logic [IDX_W-1:0]   wr_addr_i,
  input  logic [IDX_W-1:0]   rd_addr_i,
  input  cer_pkg::entry_t    wr_data_i,
  output cer_pkg::entry_t    rd_data_o
);
  import cer_pkg::*;

  localparam int KA_W  = 5 + 16 + 16 + 16 + 16;
  localparam int VST_W = 32 * 3;

  // Key and attributes are written only on append; value, sequence and
  // time are also rewritten when a push coalesces.
  logic [KA_W-1:0]  ka_mem  [DEPTH];
  logic [VST_W-1:0] vst_mem [DEPTH];
  logic [KA_W-1:0]  ka_q;
  logic [VST_W-1:0] vst_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_all) begin
      ka_mem[wr_addr_i] <= wr_data_i[KA_W-1:0];
    end
    if (ctl_i.wr_all || ctl_i.wr_upd) begin
      vst_mem[wr_addr_i] <= wr_data_i[ENTRY_W-1:KA_W];
    end
    if (ctl_i.rd_en) begin
      ka_q  <= ka_mem[rd_addr_i];
      vst_q <= vst_mem[rd_addr_i];
    end
  end

  assign rd_data_o = entry_t'({vst_q, ka_q});

endmodule

// File: rtl/core/cer_ctrl.sv
module cer_ctrl #(
  parameter int MAX_DEPTH = cer_pkg::MAX_DEPTH_DEF,
  parameter int IDX_W     = $clog2(MAX_DEPTH),
  parameter int CNT_W     = $clog2(MAX_DEPTH + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cer_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cer_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            s_valid_i,
  output logic                            s_ready_o,
  input  logic                            s_kind_i,
  input  cer_pkg::entry_t                 s_event_i,
  output logic                            m_valid_o,
  input  logic                            m_ready_i,
  output cer_pkg::result_t                m_result_o,
  output cer_pkg::mem_ctl_t               mem_ctl_o,
  output logic [IDX_W-1:0]                wr_addr_o,
  output logic [IDX_W-1:0]                rd_addr_o,
  output cer_pkg::entry_t                 wr_data_o,
  input  cer_pkg::entry_t                 rd_data_i
);
  import cer_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPEND,
    S_POP_DAT,
    S_OUT
  } state_e;

  // Configuration registers
  logic        coal_en_q;
  logic [31:0] motion_q;
  logic [4:0]  ovf_type_q;
  logic [15:0] none_std_q;
  logic [15:0] owner_q;
  logic [4:0]  depth_q;

  state_e            state_q, state_d;
  entry_t            ev_q, ev_d;
  result_t           res_q, res_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [IDX_W-1:0]  tail_q, tail_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic              ovf_q, ovf_d;
  logic [DROP_W-1:0] drop_q, drop_d;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0]  cmp_idx_q, cmp_idx_d;
  logic [CNT_W-1:0]  issue_q, issue_d;
  logic              cmp_vld_q, cmp_vld_d;

  logic [CNT_W-1:0]  eff_depth;
  logic              key_match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coal_en_q  <= 1'b0;
      motion_q   <= '0;
      ovf_type_q <= '0;
      none_std_q <= '0;
      owner_q    <= '0;
      depth_q    <= DEPTH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COAL_EN:   coal_en_q  <= cfg_data_i[0];
        CFG_MOTION:    motion_q   <= cfg_data_i;
        CFG_OVF_TYPE:  ovf_type_q <= cfg_data_i[4:0];
        CFG_NONE_STD:  none_std_q <= cfg_data_i[15:0];
        CFG_OWNER_DEV: owner_q    <= cfg_data_i[15:0];
        CFG_DEPTH:     depth_q    <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Zero counts as one entry, anything above the storage as full storage.
  always_comb begin
    if (depth_q == '0) begin
      eff_depth = CNT_W'(1);
    end else if (32'(depth_q) > MAX_DEPTH) begin
      eff_depth = CNT_W'(MAX_DEPTH);
    end else begin
      eff_depth = CNT_W'(depth_q);
    end
  end

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] d);
    logic [CNT_W:0] n;
    n = (CNT_W+1)'(idx) + 1'b1;
    if (n >= (CNT_W+1)'(d)) begin
      return '0;
    end
    return IDX_W'(n);
  endfunction

  assign key_match = ({rd_data_i.event_type, rd_data_i.event_device, rd_data_i.event_code} ==
                      {ev_q.event_type, ev_q.event_device, ev_q.event_code});

  always_comb begin
    state_d   = state_q;
    ev_d      = ev_q;
    res_d     = res_q;
    head_d    = head_q;
    tail_d    = tail_q;
    fill_d    = fill_q;
    ovf_d     = ovf_q;
    drop_d    = drop_q;
    rd_idx_d  = rd_idx_q;
    cmp_idx_d = cmp_idx_q;
    issue_d   = issue_q;
    cmp_vld_d = cmp_vld_q;
    mem_ctl_o = '0;
    wr_addr_o = tail_q;
    rd_addr_o = (state_q == S_SCAN) ? rd_idx_q : head_q;
    wr_data_o = ev_q;

    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          ev_d  = s_event_i;
          res_d = '0;
          if (s_kind_i == KIND_POP) begin
            if (fill_q != '0) begin
              mem_ctl_o.rd_en = 1'b1;
              state_d = S_POP_DAT;
            end else if (ovf_q) begin
              res_d.status    = ST_POP_OVF;
              res_d.ev_type   = ovf_type_q;
              res_d.ev_device = owner_q;
              res_d.ev_std    = none_std_q;
              res_d.ev_value  = signed'({1'b0, drop_q});
              res_d.queued    = QUEUED_W'(fill_q);
              ovf_d   = 1'b0;
              drop_d  = '0;
              state_d = S_OUT;
            end else begin
              res_d.status = ST_EMPTY;
              res_d.queued = QUEUED_W'(fill_q);
              state_d = S_OUT;
            end
          end else if (coal_en_q && motion_q[s_event_i.event_type]) begin
            rd_idx_d  = head_q;
            issue_d   = '0;
            cmp_vld_d = 1'b0;
            state_d   = S_SCAN;
          end else begin
            state_d = S_APPEND;
          end
        end
      end

      // Read one entry per cycle from head; compare the one read last cycle.
      S_SCAN: begin
        if (cmp_vld_q && key_match) begin
          mem_ctl_o.wr_upd = 1'b1;
          wr_addr_o    = cmp_idx_q;
          res_d.status = ST_COALESCED;
          res_d.queued = QUEUED_W'(fill_q);
          state_d = S_OUT;
        end else if (issue_q != fill_q) begin
          mem_ctl_o.rd_en = 1'b1;
          rd_idx_d  = next_idx(rd_idx_q, eff_depth);
          cmp_idx_d = rd_idx_q;
          issue_d   = CNT_W'(issue_q + 1'b1);
          cmp_vld_d = 1'b1;
        end else begin
          cmp_vld_d = 1'b0;
          if (!cmp_vld_q) begin
            state_d = S_APPEND;
          end
        end
      end

      S_APPEND: begin
        if (fill_q >= eff_depth) begin
          ovf_d = 1'b1;
          if (drop_q != '1) begin
            drop_d = DROP_W'(drop_q + 1'b1);
          end
          res_d.status = ST_DROPPED;
          res_d.queued = QUEUED_W'(fill_q);
        end else begin
          mem_ctl_o.wr_all = 1'b1;
          tail_d = next_idx(tail_q, eff_depth);
          fill_d = CNT_W'(fill_q + 1'b1);
          res_d.status = ST_STORED;
          res_d.queued = QUEUED_W'(CNT_W'(fill_q + 1'b1));
        end
        state_d = S_OUT;
      end

      S_POP_DAT: begin
        res_d.status      = ST_POPPED;
        res_d.ev_type     = rd_data_i.event_type;
        res_d.ev_device   = rd_data_i.event_device;
        res_d.ev_code     = rd_data_i.event_code;
        res_d.ev_std      = rd_data_i.std_code;
        res_d.ev_flags    = rd_data_i.event_flags;
        res_d.ev_value    = rd_data_i.event_value;
        res_d.ev_sequence = rd_data_i.event_sequence;
        res_d.ev_time     = rd_data_i.event_time;
        res_d.queued      = QUEUED_W'(CNT_W'(fill_q - 1'b1));
        head_d  = next_idx(head_q, eff_depth);
        fill_d  = CNT_W'(fill_q - 1'b1);
        state_d = S_OUT;
      end

      S_OUT: begin
        if (m_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ev_q      <= '0;
      res_q     <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      fill_q    <= '0;
      ovf_q     <= 1'b0;
      drop_q    <= '0;
      rd_idx_q  <= '0;
      cmp_idx_q <= '0;
      issue_q   <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ev_q      <= ev_d;
      res_q     <= res_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      fill_q    <= fill_d;
      ovf_q     <= ovf_d;
      drop_q    <= drop_d;
      rd_idx_q  <= rd_idx_d;
      cmp_idx_q <= cmp_idx_d;
      issue_q   <= issue_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  assign s_ready_o  = (state_q == S_IDLE);
  assign m_valid_o  = (state_q == S_OUT);
  assign m_result_o = res_q;

endmodule

// File: rtl/core/coalescing_event_ring_top.sv
// Event ring for one input consumer. Each request on the slave stream is a push
// (tuser 0) or a pop (tuser 1) and yields exactly one result on the master stream.
// The block handles one request at a time: ready drops on acceptance and returns
// the cycle after the result is taken. A plain push, a pop that returns a queued
// entry and a push of a type that is not coalesced pass through one append or
// pop-data state before the result state; a pop of an empty ring goes straight to
// the result state. A push that may coalesce walks the queued entries from head
// through the single read port of the ring storage and one key comparator, one
// entry per cycle, and stops at the first match. Write configuration only while no
// request is in flight; the ring storage is not cleared at reset and needs no
// clearing pass.
module coalescing_event_ring_top #(
  parameter int MAX_DEPTH = cer_pkg::MAX_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cer_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cer_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // event_type, event_device, event_code, std_code, event_flags, event_value,
  // event_sequence, event_time
  input  logic [cer_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // kind
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // status, ev_type, ev_device, ev_code, ev_std, ev_flags, ev_value,
  // ev_sequence, ev_time, queued
  output logic [cer_pkg::M_DATA_W-1:0]   m_axis_tdata
);
  import cer_pkg::*;

  localparam int IDX_W = $clog2(MAX_DEPTH);
  localparam int CNT_W = $clog2(MAX_DEPTH + 1);

  entry_t           s_event;
  result_t          m_result;
  mem_ctl_t         mem_ctl;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  entry_t           wr_data;
  entry_t           rd_data;

  assign s_event      = entry_t'(s_axis_tdata[ENTRY_W-1:0]);
  assign m_axis_tdata = M_DATA_W'(m_result);

  cer_ctrl #(
    .MAX_DEPTH (MAX_DEPTH),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .s_kind_i   (s_axis_tuser),
    .s_event_i  (s_event),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_result_o (m_result),
    .mem_ctl_o  (mem_ctl),
    .wr_addr_o  (wr_addr),
    .rd_addr_o  (rd_addr),
    .wr_data_o  (wr_data),
    .rd_data_i  (rd_data)
  );

  cer_mem #(
    .DEPTH (MAX_DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .wr_addr_i (wr_addr),
    .rd_addr_i (rd_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

endmodule

// File: rtl/core/cer_chk.sv
module cer_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [cer_pkg::M_DATA_W-1:0]   m_axis_tdata
);
  import cer_pkg::*;

  logic [2:0]          status;
  logic [QUEUED_W-1:0] queued;

  assign status = m_axis_tdata[2:0];
  assign queued = m_axis_tdata[RESULT_W-1 -: QUEUED_W];

  // One request at a time: never ready while a result waits.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while busy");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (status == ST_STORED || status == ST_COALESCED ||
                       status == ST_DROPPED || status == ST_POPPED ||
                       status == ST_POP_OVF || status == ST_EMPTY))
    else $error("undefined status code");

  a_empty_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (status == ST_EMPTY || status == ST_POP_OVF)) |-> (queued == '0))
    else $error("empty or overflow pop with entries held");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");

endmodule

bind coalescing_event_ring_top cer_chk u_cer_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: bench/coalescing_event_ring_top_tb.sv
module coalescing_event_ring_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cer_pkg::*;

  typedef struct {
    logic    kind;
    entry_t  ev;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_axis_tdata;

  // shadow of the ring and its registers
  entry_t      ring_slot [MAX_DEPTH_DEF];
  int          ring_head, ring_tail, ring_fill;
  bit          ring_ovf;
  logic [30:0] ring_drops;
  bit          c_coal;
  logic [31:0] c_mask;
  logic [4:0]  c_ovf_type;
  logic [15:0] c_none_std;
  logic [15:0] c_owner;
  logic [4:0]  c_depth;

  result_t     pending_results [$];
  dir_row_t    dir_rows [$];
  logic [4:0]  pool_type [4];
  logic [15:0] pool_dev [3];
  logic [15:0] pool_code [3];

  bit idle_on = 1'b0;
  bit last_part = 1'b0;
  bit hold_start = 1'b0;
  int hold_left = 0;
  int stall_left = 0;
  int n_requests = 0;
  int n_checked = 0;
  int n_errors = 0;
  int seen_status [6];

  result_t got, want;
  string   bad;

  coalescing_event_ring_top #(
    .MAX_DEPTH(MAX_DEPTH_DEF)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  function automatic int eff_depth(logic [4:0] dv);
    if (dv == 5'd0) return 1;
    if (dv > MAX_DEPTH_DEF) return MAX_DEPTH_DEF;
    return int'(dv);
  endfunction

  function automatic int ring_next(int idx, int d);
    return (idx + 1 >= d) ? 0 : idx + 1;
  endfunction

  // advance the shadow ring by one request and return the result it yields
  function automatic result_t ring_apply(logic kind, entry_t ev);
    result_t r;
    int      d;
    int      idx;
    bit      merged;
    r = '0;
    d = eff_depth(c_depth);
    merged = 1'b0;
    if (kind == KIND_PUSH) begin
      if (c_coal && c_mask[ev.event_type]) begin
        idx = ring_head;
        for (int i = 0; i < ring_fill; i++) begin
          if (!merged && ring_slot[idx].event_type == ev.event_type &&
              ring_slot[idx].event_device == ev.event_device &&
              ring_slot[idx].event_code == ev.event_code) begin
            ring_slot[idx].event_value    = ev.event_value;
            ring_slot[idx].event_sequence = ev.event_sequence;
            ring_slot[idx].event_time     = ev.event_time;
            merged = 1'b1;
          end
          idx = ring_next(idx, d);
        end
      end
      if (merged) begin
        r.status = ST_COALESCED;
      end else if (ring_fill >= d) begin
        ring_ovf = 1'b1;
        if (ring_drops != '1) ring_drops++;
        r.status = ST_DROPPED;
      end else begin
        ring_slot[ring_tail] = ev;
        ring_tail = ring_next(ring_tail, d);
        ring_fill++;
        r.status = ST_STORED;
      end
    end else if (ring_fill != 0) begin
      r.ev_type     = ring_slot[ring_head].event_type;
      r.ev_device   = ring_slot[ring_head].event_device;
      r.ev_code     = ring_slot[ring_head].event_code;
      r.ev_std      = ring_slot[ring_head].std_code;
      r.ev_flags    = ring_slot[ring_head].event_flags;
      r.ev_value    = ring_slot[ring_head].event_value;
      r.ev_sequence = ring_slot[ring_head].event_sequence;
      r.ev_time     = ring_slot[ring_head].event_time;
      ring_head = ring_next(ring_head, d);
      ring_fill--;
      r.status = ST_POPPED;
    end else if (ring_ovf) begin
      r.ev_type   = c_ovf_type;
      r.ev_device = c_owner;
      r.ev_std    = c_none_std;
      r.ev_value  = {1'b0, ring_drops};
      ring_ovf   = 1'b0;
      ring_drops = '0;
      r.status = ST_POP_OVF;
    end else begin
      r.status = ST_EMPTY;
    end
    r.queued = ring_fill[4:0];
    return r;
  endfunction

  function automatic entry_t mk_ev(logic [4:0] typ, logic [15:0] dev, logic [15:0] code,
                                   logic [15:0] std, logic [15:0] flg, logic [31:0] val,
                                   logic [31:0] seq, logic [31:0] tim);
    entry_t e;
    e.event_type     = typ;
    e.event_device   = dev;
    e.event_code     = code;
    e.std_code       = std;
    e.event_flags    = flg;
    e.event_value    = val;
    e.event_sequence = seq;
    e.event_time     = tim;
    return e;
  endfunction

  function automatic result_t mk_res(status_e st, logic [4:0] typ, logic [15:0] dev,
                                     logic [15:0] std, logic [31:0] val, logic [4:0] q);
    result_t r;
    r = '0;
    r.status    = st;
    r.ev_type   = typ;
    r.ev_device = dev;
    r.ev_std    = std;
    r.ev_value  = val;
    r.queued    = q;
    return r;
  endfunction

  // keys mostly come from small pools so that repeats and merges are common
  function automatic entry_t rand_event();
    entry_t e;
    e.event_type = ($urandom_range(0, 4) == 0) ? 5'($urandom())
                                               : pool_type[$urandom_range(0, 3)];
    e.event_device = ($urandom_range(0, 4) == 0) ? 16'($urandom())
                                                 : pool_dev[$urandom_range(0, 2)];
    e.event_code = ($urandom_range(0, 4) == 0) ? 16'($urandom())
                                               : pool_code[$urandom_range(0, 2)];
    e.std_code       = 16'($urandom());
    e.event_flags    = 16'($urandom());
    e.event_value    = $urandom();
    e.event_sequence = $urandom();
    e.event_time     = $urandom();
    return e;
  endfunction

  function automatic void new_pools();
    for (int i = 0; i < 4; i++) pool_type[i] = 5'($urandom());
    for (int i = 0; i < 3; i++) begin
      pool_dev[i]  = 16'($urandom());
      pool_code[i] = 16'($urandom());
    end
    pool_dev[0]  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    pool_code[0] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
  endfunction

  function automatic void add_row(logic kind, entry_t ev, bit typed, result_t w);
    dir_row_t row;
    row.kind  = kind;
    row.ev    = ev;
    row.typed = typed;
    row.want  = w;
    dir_rows.push_back(row);
  endfunction

  function automatic string fmt_res(result_t r);
    return $sformatf("st=%0d ty=%h dev=%h code=%h std=%h flg=%h val=%h seq=%h tim=%h q=%0d",
                     r.status, r.ev_type, r.ev_device, r.ev_code, r.ev_std, r.ev_flags,
                     r.ev_value, r.ev_sequence, r.ev_time, r.queued);
  endfunction

  function automatic string diff_fields(result_t w, result_t g);
    string s;
    s = "";
    if (g.status !== w.status) s = {s, " status"};
    if (g.ev_type !== w.ev_type) s = {s, " ev_type"};
    if (g.ev_device !== w.ev_device) s = {s, " ev_device"};
    if (g.ev_code !== w.ev_code) s = {s, " ev_code"};
    if (g.ev_std !== w.ev_std) s = {s, " ev_std"};
    if (g.ev_flags !== w.ev_flags) s = {s, " ev_flags"};
    if (g.ev_value !== w.ev_value) s = {s, " ev_value"};
    if (g.ev_sequence !== w.ev_sequence) s = {s, " ev_sequence"};
    if (g.ev_time !== w.ev_time) s = {s, " ev_time"};
    if (g.queued !== w.queued) s = {s, " queued"};
    return s;
  endfunction

  // offer one request, hold it until taken, then queue what it should yield
  task automatic send_req(logic kind, entry_t ev, bit typed, result_t w);
    result_t r;
    int      gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_DATA_W'(ev);
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    r = ring_apply(kind, ev);
    pending_results.push_back(typed ? w : r);
    n_requests++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_COAL_EN:   c_coal = data[0];
      CFG_MOTION:    c_mask = data;
      CFG_OVF_TYPE:  c_ovf_type = data[4:0];
      CFG_NONE_STD:  c_none_std = data[15:0];
      CFG_OWNER_DEV: c_owner = data[15:0];
      CFG_DEPTH:     c_depth = data[4:0];
      default: ;
    endcase
  endtask

  // upper data bits carry junk that the block must mask off
  task automatic apply_setting(bit coal, logic [31:0] mask, logic [4:0] ovf,
                               logic [15:0] nstd, logic [15:0] owner, logic [4:0] depth);
    int nd;
    nd = eff_depth(depth);
    wait_idle();
    // keep held entries only if they stay contiguous below the new depth
    if (ring_fill > 0 && !(ring_head < ring_tail && ring_tail < nd)) begin
      while (ring_fill > 0) send_req(KIND_POP, rand_event(), 1'b0, '0);
      wait_idle();
    end
    cfg_write(CFG_COAL_EN, {31'($urandom()), coal});
    cfg_write(CFG_MOTION, mask);
    cfg_write(CFG_OVF_TYPE, {27'($urandom()), ovf});
    cfg_write(CFG_NONE_STD, {16'($urandom()), nstd});
    cfg_write(CFG_OWNER_DEV, {16'($urandom()), owner});
    cfg_write(CFG_DEPTH, {27'($urandom()), depth});
    cfg_we_i <= 1'b0;
    new_pools();
  endtask

  task automatic run_items(int n);
    int bias;
    bias = 5;
    for (int k = 0; k < n; k++) begin
      if (k % 20 == 0) begin
        bias = 2 + 3 * $urandom_range(0, 2);
        if (!last_part) idle_on = ($urandom_range(0, 3) != 0);
      end
      send_req(($urandom_range(0, 9) < bias) ? KIND_PUSH : KIND_POP,
               rand_event(), 1'b0, '0);
    end
  endtask

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_start) begin
      hold_left = 240;
      hold_start = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      got = result_t'(m_axis_tdata[RESULT_W-1:0]);
      if (int'(got.status) < 6) seen_status[int'(got.status)]++;
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result: %s", fmt_res(got));
      end else begin
        want = pending_results.pop_front();
        bad = diff_fields(want, got);
        n_checked++;
        if (bad != "") begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch in%s\n  want %s\n  got  %s", bad, fmt_res(want), fmt_res(got));
        end
      end
    end
  end

  initial begin
    #10ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    ring_head = 0;
    ring_tail = 0;
    ring_fill = 0;
    ring_ovf = 1'b0;
    ring_drops = '0;
    c_coal = 1'b0;
    c_mask = '0;
    c_ovf_type = '0;
    c_none_std = '0;
    c_owner = '0;
    c_depth = DEPTH_RESET;
    for (int i = 0; i < 6; i++) seen_status[i] = 0;
    new_pools();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part: depth 3, types 3 and 31 may merge
    apply_setting(1'b1, 32'h8000_0008, 5'd31, 16'hFFFF, 16'hABCD, 5'd3);
    add_row(KIND_POP, rand_event(), 1'b1, mk_res(ST_EMPTY, 0, 0, 0, 0, 0));
    add_row(KIND_PUSH, mk_ev(3, 16'hFFFF, 0, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF,
                             32'hFFFF_FFFF, 32'hFFFF_FFFF),
            1'b1, mk_res(ST_STORED, 0, 0, 0, 0, 1));
    add_row(KIND_PUSH, mk_ev(0, 0, 16'hFFFF, 0, 0, 32'h8000_0000, 0, 0),
            1'b1, mk_res(ST_STORED, 0, 0, 0, 0, 2));
    add_row(KIND_PUSH, mk_ev(3, 16'hFFFF, 0, 16'h1234, 16'h5678, 32'hFFFF_FFFF, 5, 6),
            1'b1, mk_res(ST_COALESCED, 0, 0, 0, 0, 2));
    add_row(KIND_PUSH, mk_ev(31, 1, 2, 7, 8, 9, 10, 11),
            1'b1, mk_res(ST_STORED, 0, 0, 0, 0, 3));
    add_row(KIND_PUSH, mk_ev(31, 1, 2, 0, 0, -5, 12, 13),
            1'b1, mk_res(ST_COALESCED, 0, 0, 0, 0, 3));
    add_row(KIND_PUSH, mk_ev(0, 0, 16'hFFFF, 1, 1, 1, 1, 1),
            1'b1, mk_res(ST_DROPPED, 0, 0, 0, 0, 3));
    add_row(KIND_PUSH, mk_ev(3, 16'hFFFF, 1, 2, 2, 2, 2, 2),
            1'b1, mk_res(ST_DROPPED, 0, 0, 0, 0, 3));
    add_row(KIND_POP, rand_event(), 1'b0, '0);
    add_row(KIND_POP, rand_event(), 1'b0, '0);
    add_row(KIND_PUSH, mk_ev(3, 16'hFFFF, 0, 3, 3, 3, 3, 3), 1'b0, '0);
    add_row(KIND_POP, rand_event(), 1'b0, '0);
    add_row(KIND_POP, rand_event(), 1'b0, '0);
    add_row(KIND_POP, rand_event(), 1'b1, mk_res(ST_POP_OVF, 31, 16'hABCD, 16'hFFFF, 2, 0));
    add_row(KIND_POP, rand_event(), 1'b1, mk_res(ST_EMPTY, 0, 0, 0, 0, 0));
    add_row(KIND_PUSH, mk_ev(31, 0, 0, 4, 4, 4, 4, 4), 1'b0, '0);
    add_row(KIND_PUSH, mk_ev(3, 0, 0, 5, 5, 5, 5, 5), 1'b0, '0);
    add_row(KIND_PUSH, mk_ev(31, 16'hFFFF, 16'hFFFF, 6, 6, 6, 6, 6), 1'b0, '0);
    add_row(KIND_PUSH, mk_ev(3, 0, 0, 7, 7, 77, 78, 79), 1'b0, '0);
    add_row(KIND_PUSH, mk_ev(4, 0, 0, 8, 8, 8, 8, 8),
            1'b1, mk_res(ST_DROPPED, 0, 0, 0, 0, 3));
    add_row(KIND_POP, rand_event(), 1'b0, '0);
    add_row(KIND_POP, rand_event(), 1'b0, '0);
    add_row(KIND_POP, rand_event(), 1'b0, '0);
    add_row(KIND_POP, rand_event(), 1'b1, mk_res(ST_POP_OVF, 31, 16'hABCD, 16'hFFFF, 1, 0));
    idle_on = 1'b1;
    foreach (dir_rows[i]) send_req(dir_rows[i].kind, dir_rows[i].ev, dir_rows[i].typed,
                                   dir_rows[i].want);

    // random part over a spread of settings
    apply_setting(1'b1, $urandom(), 5'd0, 16'h0000, 16'h0000, 5'd16);
    run_items(40);
    hold_start = 1'b1;
    run_items(180);
    apply_setting(1'b1, 32'hFFFF_FFFF, 5'd31, 16'hFFFF, 16'hFFFF, 5'd1);
    run_items(200);
    apply_setting(1'b0, 32'hFFFF_FFFF, 5'($urandom()), 16'($urandom()), 16'($urandom()),
                  5'd16);
    run_items(200);
    apply_setting(1'b1, 32'h0000_0000, 5'($urandom()), 16'($urandom()), 16'($urandom()),
                  5'd31);
    run_items(200);
    apply_setting(1'b1, $urandom(), 5'($urandom()), 16'($urandom()), 16'($urandom()),
                  5'($urandom_range(2, 8)));
    run_items(200);
    apply_setting(1'b1, 32'hFFFF_FFFF, 5'($urandom()), 16'($urandom()), 16'($urandom()),
                  5'd0);
    run_items(120);
    apply_setting(1'b1, $urandom() | 32'h0000_FFFF, 5'($urandom()), 16'($urandom()),
                  16'($urandom()), 5'($urandom_range(9, 16)));
    // steady traffic to close out
    last_part = 1'b1;
    idle_on = 1'b0;
    run_items(330);

    wait_idle();
    repeat (40) @(posedge clk_i);
    $display("covered %0d requests at several ring depths and merge settings, %0d results checked",
             n_requests, n_checked);
    $display("outcomes: stored %0d merged %0d dropped %0d popped %0d overflow %0d empty %0d",
             seen_status[0], seen_status[1], seen_status[2], seen_status[3],
             seen_status[4], seen_status[5]);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d failures", n_errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
